// ----- rtl/pjh_pkg.sv -----
// shared types and constants of the period jitter histogram
`default_nettype none

package pjh_pkg;

    // default number of histogram bins
    localparam int PJH_BINS = 64;

    // depth of the internal queues and the width of their fill counts
    localparam int PJH_QUEUE_DEPTH = 4;
    localparam int PJH_QCW = $clog2(PJH_QUEUE_DEPTH + 1);

    // what an item turned out to be once classified
    typedef enum logic [1:0] {
        KIND_READ,
        KIND_BASE,
        KIND_EVENT
    } t_kind;

    // classified item handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [5:0]  bin_index;
        logic [31:0] jitter;
        logic [31:0] max_jitter;
    } t_op;

    // one finished result
    typedef struct packed {
        logic        sample_valid;
        logic [31:0] sample_jitter;
        logic [31:0] bin_count;
        logic [31:0] max_jitter;
    } t_res;

endpackage

`default_nettype wire

// ----- rtl/pjh_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module pjh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pjh_fifo.sv -----
// small register fifo with fill count
`default_nettype none

module pjh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic      [WIDTH-1:0]           o_data,
    output logic                            o_empty,
    output logic                            o_full,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pjh_front.sv -----
// front end: takes items, tracks the baseline and measures jitter and maximum
`default_nettype none

module pjh_front import pjh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_mode,
    input  wire logic [31:0] i_timestamp,
    input  wire logic [5:0]  i_bin_index,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    output logic             o_stage_busy,
    output logic             o_op_push,
    output t_op              o_op
);

    logic [31:0] r_nom_period;
    logic [31:0] r_last_ts;
    logic        r_have_base;
    logic [31:0] r_max, n_max;

    // first stage: classified item with its raw interval
    logic        r_f_valid;
    t_kind       r_f_kind, n_f_kind;
    logic [31:0] r_f_interval;
    logic [5:0]  r_f_bin_index;

    logic [31:0] w_jit;
    logic        w_is_event;

    // classify the incoming transaction
    always_comb begin
        if (i_mode) begin
            n_f_kind = KIND_READ;
        end else if (!r_have_base) begin
            n_f_kind = KIND_BASE;
        end else begin
            n_f_kind = KIND_EVENT;
        end
    end

    // absolute deviation and running maximum
    always_comb begin
        if (r_f_interval > r_nom_period) begin
            w_jit = r_f_interval - r_nom_period;
        end else begin
            w_jit = r_nom_period - r_f_interval;
        end
        w_is_event = r_f_valid && (r_f_kind == KIND_EVENT);
        n_max = (w_is_event && (w_jit > r_max)) ? w_jit : r_max;
    end

    assign o_stage_busy     = r_f_valid;
    assign o_op_push        = r_f_valid;
    assign o_op.kind        = r_f_kind;
    assign o_op.bin_index   = r_f_bin_index;
    assign o_op.jitter      = (r_f_kind == KIND_EVENT) ? w_jit : '0;
    assign o_op.max_jitter  = n_max;

    // control and measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nom_period <= '0;
            r_last_ts    <= '0;
            r_have_base  <= 1'b0;
            r_max        <= '0;
            r_f_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_nom_period <= i_cfg_wr_data;
            end
            if (i_accept && !i_mode) begin
                r_last_ts   <= i_timestamp;
                r_have_base <= 1'b1;
            end
            r_max     <= n_max;
            r_f_valid <= i_accept;
        end
    end

    // first stage payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_f_kind      <= n_f_kind;
            r_f_interval  <= i_timestamp - r_last_ts;
            r_f_bin_index <= i_bin_index;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pjh_back.sv -----
// back end: clears the histogram, then updates and reads bins in the ram
`default_nettype none

module pjh_back import pjh_pkg::*; #(
    parameter int BINS = PJH_BINS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_op                     i_op,
    input  wire logic               i_op_empty,
    output logic                    o_op_pop,
    input  wire logic [PJH_QCW-1:0] i_res_count,
    output logic                    o_res_push,
    output t_res                    o_res,
    output logic                    o_clearing
);

    localparam int AW = $clog2(BINS);
    localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // issue stage
    logic          w_issue;
    logic [PJH_QCW:0] w_res_used;
    logic [31:0]   w_idx_ext;
    logic          w_read_oor;
    logic [AW-1:0] w_rd_addr;

    // update stage
    logic          r_b1_valid;
    t_op           r_b1_op;
    logic [AW-1:0] r_b1_addr;
    logic          r_b1_oor;
    logic [31:0]   w_ram_data;
    logic [31:0]   w_cur_count;
    logic          w_b1_write;

    // last bin write, forwarded to the next update
    logic          r_fw_valid;
    logic [AW-1:0] r_fw_addr;
    logic [31:0]   r_fw_data;

    // ram port selection
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;

    assign o_clearing = r_clr_busy;

    // issue only with room for every result in flight
    assign w_res_used = {1'b0, i_res_count} + (PJH_QCW + 1)'(r_b1_valid);
    assign w_issue    = !r_clr_busy && !i_op_empty
                        && (w_res_used < (PJH_QCW + 1)'(PJH_QUEUE_DEPTH));
    assign o_op_pop   = w_issue;

    // bin address: requested index for reads, clamped deviation for events
    always_comb begin
        w_idx_ext  = 32'(i_op.bin_index);
        w_read_oor = (w_idx_ext >= 32'(BINS));
        case (i_op.kind)
            KIND_READ:  w_rd_addr = w_idx_ext[AW-1:0];
            KIND_EVENT: w_rd_addr = (i_op.jitter >= 32'(BINS - 1)) ?
                                    LAST_BIN : i_op.jitter[AW-1:0];
            default:    w_rd_addr = '0;
        endcase
    end

    // count with forwarding of the write made in the previous cycle
    assign w_cur_count = (r_fw_valid && (r_fw_addr == r_b1_addr)) ? r_fw_data : w_ram_data;
    assign w_b1_write  = r_b1_valid && (r_b1_op.kind == KIND_EVENT);

    // write port: clearing pass first, then bin increments
    always_comb begin
        if (r_clr_busy) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = w_b1_write;
            w_wr_addr = r_b1_addr;
            w_wr_data = w_cur_count + 32'd1;
        end
    end

    pjh_ram #(
        .WIDTH (32),
        .DEPTH (BINS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_data)
    );

    // result of the update stage
    assign o_res_push          = r_b1_valid;
    assign o_res.sample_valid  = (r_b1_op.kind == KIND_EVENT);
    assign o_res.sample_jitter = r_b1_op.jitter;
    assign o_res.bin_count     = ((r_b1_op.kind == KIND_READ) && !r_b1_oor) ? w_cur_count : '0;
    assign o_res.max_jitter    = r_b1_op.max_jitter;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_b1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_BIN) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_b1_valid <= w_issue;
            r_fw_valid <= w_b1_write;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_b1_op   <= i_op;
            r_b1_addr <= w_rd_addr;
            r_b1_oor  <= w_read_oor;
        end
        r_fw_addr <= r_b1_addr;
        r_fw_data <= w_wr_data;
    end

endmodule

`default_nettype wire

// ----- rtl/period_jitter_histogram.sv -----
// Period jitter histogram, top level. Timestamped events of a periodic task
// come in through a queue-like port; the first event after reset sets the
// baseline, and every later one gives the absolute deviation of its interval
// (modulo 2^32) from the configured nominal period, updates the running
// maximum and counts the deviation into one of BINS bins, the last bin
// catching everything from BINS-1 up. A read item returns one bin count with
// the maximum. Each item gives one result. One item per clock is sustained
// while pop keeps up; a taken item passes the front stage, the op queue, the
// update stage and the result queue before its result is ready, and is held
// up further only when pop holds off. The rate is set by the single write port
// of the bin ram, whose read-modify-write is closed by forwarding the previous
// cycle's write. After reset full stays high while the bins are cleared.
`default_nettype none

module period_jitter_histogram import pjh_pkg::*; #(
    parameter int BINS = PJH_BINS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_mode,
    input  wire logic [31:0] i_timestamp,
    input  wire logic [5:0]  i_bin_index,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_sample_valid,
    output logic [31:0]      o_sample_jitter,
    output logic [31:0]      o_bin_count,
    output logic [31:0]      o_max_jitter
);

    logic               w_accept;
    logic               w_stage_busy;
    logic               w_op_push;
    t_op                w_op_in;
    logic [$bits(t_op)-1:0] w_op_out_bits;
    t_op                w_op_out;
    logic               w_op_empty;
    logic               w_op_full;
    logic [PJH_QCW-1:0] w_op_count;
    logic [PJH_QCW:0]   w_op_used;
    logic               w_op_pop;
    logic               w_res_push;
    t_res               w_res_in;
    logic [$bits(t_res)-1:0] w_res_out_bits;
    t_res               w_res_out;
    logic               w_res_full;
    logic [PJH_QCW-1:0] w_res_count;
    logic               w_clearing;

    // input side: hold off while clearing or when the queue could overflow
    assign w_op_used = {1'b0, w_op_count} + (PJH_QCW + 1)'(w_stage_busy);
    assign full      = w_clearing || w_op_full
                       || (w_op_used >= (PJH_QCW + 1)'(PJH_QUEUE_DEPTH));
    assign w_accept  = push && !full;

    pjh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_mode        (i_mode),
        .i_timestamp   (i_timestamp),
        .i_bin_index   (i_bin_index),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_stage_busy  (w_stage_busy),
        .o_op_push     (w_op_push),
        .o_op          (w_op_in)
    );

    // queue between front and back
    pjh_fifo #(
        .WIDTH ($bits(t_op)),
        .DEPTH (PJH_QUEUE_DEPTH)
    ) u_op_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_push),
        .i_data  (w_op_in),
        .i_pop   (w_op_pop),
        .o_data  (w_op_out_bits),
        .o_empty (w_op_empty),
        .o_full  (w_op_full),
        .o_count (w_op_count)
    );

    assign w_op_out = t_op'(w_op_out_bits);

    pjh_back #(
        .BINS (BINS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op_out),
        .i_op_empty  (w_op_empty),
        .o_op_pop    (w_op_pop),
        .i_res_count (w_res_count),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .o_clearing  (w_clearing)
    );

    // result queue
    pjh_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (PJH_QUEUE_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push && !w_res_full),
        .i_data  (w_res_in),
        .i_pop   (pop),
        .o_data  (w_res_out_bits),
        .o_empty (empty),
        .o_full  (w_res_full),
        .o_count (w_res_count)
    );

    assign w_res_out       = t_res'(w_res_out_bits);
    assign o_sample_valid  = w_res_out.sample_valid;
    assign o_sample_jitter = w_res_out.sample_jitter;
    assign o_bin_count     = w_res_out.bin_count;
    assign o_max_jitter    = w_res_out.max_jitter;

endmodule

`default_nettype wire

// ----- rtl/pjh_checker.sv -----
// port-level checks of the period jitter histogram and their binding
`default_nettype none

module pjh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        o_sample_valid,
    input wire logic [31:0] o_sample_jitter,
    input wire logic [31:0] o_bin_count,
    input wire logic [31:0] o_max_jitter
);

    // bins are being cleared straight after reset
    a_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("full low right after reset");

    // a read or baseline transaction carries no deviation
    a_no_jitter_unmeasured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_sample_valid) |-> (o_sample_jitter == 32'd0))
        else $error("deviation on an unmeasured result");

    // a measured transaction carries no bin count
    a_no_count_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_sample_valid) |-> (o_bin_count == 32'd0))
        else $error("bin count on an event result");

    // the maximum covers the deviation it came with
    a_max_covers_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_sample_valid) |-> (o_max_jitter >= o_sample_jitter))
        else $error("maximum below its own deviation");

    // a waiting result stays put until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_max_jitter)))
        else $error("waiting result changed");

endmodule

bind period_jitter_histogram pjh_checker u_checker (.*);

`default_nettype wire

// ----- sim/period_jitter_histogram_tb.sv -----
// self-checking testbench for the period jitter histogram
`timescale 1ns / 1ps

module period_jitter_histogram_tb;
    import pjh_pkg::*;

    // item kinds carried on i_mode
    localparam logic MODE_EVENT = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTED = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_mode;
    logic [31:0] i_timestamp;
    logic [5:0]  i_bin_index;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_sample_valid;
    logic [31:0] o_sample_jitter;
    logic [31:0] o_bin_count;
    logic [31:0] o_max_jitter;

    // predictor state, mirrors the block's histogram
    logic [31:0] nominal_period;
    logic [31:0] prev_stamp;
    logic        baseline_set;
    logic [31:0] peak_dev;
    logic [31:0] bin_tally [PJH_BINS];

    // results still to come, oldest first
    t_res hist_expect_q[$];

    // stimulus side bookkeeping
    logic [31:0] last_sent_stamp;
    bit          sender_idle_on;
    bit          receiver_idle_on;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          error_count;
    int          n_intervals;
    int          n_clamped;
    int          n_baselines;
    int          n_reads;
    int          n_checked;
    int          n_periods;

    period_jitter_histogram u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_mode         (i_mode),
        .i_timestamp    (i_timestamp),
        .i_bin_index    (i_bin_index),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .empty          (empty),
        .pop            (pop),
        .o_sample_valid (o_sample_valid),
        .o_sample_jitter(o_sample_jitter),
        .o_bin_count    (o_bin_count),
        .o_max_jitter   (o_max_jitter)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // cycle counter for the watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // one line per mismatch up to MAX_PRINTED, every mismatch counted
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTED) begin
            $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
        end
        error_count++;
    endtask

    // expected result of one item; advances the histogram state
    function automatic t_res predict_result(input logic mode, input logic [31:0] stamp,
                                            input logic [5:0] idx);
        t_res        res;
        logic [31:0] span;
        logic [31:0] dev;
        logic [$clog2(PJH_BINS)-1:0] slot;
        res = '0;
        if (mode == MODE_READ) begin
            if (idx < PJH_BINS) begin
                res.bin_count = bin_tally[idx];
            end
        end else if (!baseline_set) begin
            // first event only sets the baseline
            prev_stamp = stamp;
            baseline_set = 1'b1;
        end else begin
            span = stamp - prev_stamp;
            dev = (span > nominal_period) ? span - nominal_period : nominal_period - span;
            if (dev > peak_dev) begin
                peak_dev = dev;
            end
            // large deviations land in the last bin
            slot = (dev >= 32'(PJH_BINS - 1)) ? ($clog2(PJH_BINS))'(PJH_BINS - 1)
                                              : dev[$clog2(PJH_BINS)-1:0];
            bin_tally[slot] = bin_tally[slot] + 32'd1;
            prev_stamp = stamp;
            res.sample_valid = 1'b1;
            res.sample_jitter = dev;
        end
        res.max_jitter = peak_dev;
        return res;
    endfunction

    // result side: check each popped transaction, drive pop with stall bursts
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (hist_expect_q.size() == 0) begin
                report_mismatch("result with nothing pending", o_max_jitter, '0);
            end else begin
                want = hist_expect_q.pop_front();
                n_checked++;
                if (o_sample_valid !== want.sample_valid)
                    report_mismatch("sample_valid", 32'(o_sample_valid),
                                    32'(want.sample_valid));
                if (o_sample_jitter !== want.sample_jitter)
                    report_mismatch("sample_jitter", o_sample_jitter, want.sample_jitter);
                if (o_bin_count !== want.bin_count)
                    report_mismatch("bin_count", o_bin_count, want.bin_count);
                if (o_max_jitter !== want.max_jitter)
                    report_mismatch("max_jitter", o_max_jitter, want.max_jitter);
            end
        end
        if (stall_left != 0) begin
            pop <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            pop <= 1'b1;
        end
    end

    // send one item, with an occasional idle burst ahead of it
    task automatic send_item(input logic mode, input logic [31:0] stamp,
                             input logic [5:0] idx);
        int gap;
        if (sender_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_mode <= mode;
        i_timestamp <= stamp;
        i_bin_index <= idx;
        do @(posedge i_clk); while (full);
        hist_expect_q.push_back(predict_result(mode, stamp, idx));
        if (mode == MODE_READ) begin
            n_reads++;
        end else begin
            if (baseline_set && hist_expect_q[$].sample_valid) begin
                n_intervals++;
                if (hist_expect_q[$].sample_jitter >= 32'(PJH_BINS - 1)) n_clamped++;
            end else begin
                n_baselines++;
            end
            last_sent_stamp = stamp;
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        push <= 1'b0;
        while (hist_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // new expected period, written only with the block idle
    task automatic write_period(input logic [31:0] value);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        nominal_period = value;
        n_periods++;
    endtask

    // mostly well-formed periodic events with some noise, plus bin reads
    task automatic send_random_item(input logic [31:0] period);
        int          pick;
        int          delta;
        logic [31:0] stamp;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_item(MODE_READ, $urandom, 6'($urandom_range(0, PJH_BINS - 1)));
        end else begin
            if (pick < 85) begin
                // small jitter around the period, spreads over every bin
                delta = int'($urandom_range(0, 140)) - 70;
                stamp = last_sent_stamp + period + 32'(delta);
            end else if (pick < 95) begin
                delta = int'($urandom_range(64, 4096));
                if ($urandom_range(0, 1) == 1) delta = -delta;
                stamp = last_sent_stamp + period + 32'(delta);
            end else begin
                stamp = $urandom;
            end
            send_item(MODE_EVENT, stamp, 6'($urandom));
        end
    endtask

    // bins read back as zero once the clearing pass is over
    task automatic test_cleared_bins();
        write_period(32'h0);
        send_item(MODE_READ, 32'h0, 6'd0);
        send_item(MODE_READ, 32'hFFFF_FFFF, 6'd31);
        send_item(MODE_READ, 32'h5A5A_A5A5, 6'd63);
    endtask

    // a zero timestamp is a proper baseline
    task automatic test_baseline_zero();
        send_item(MODE_EVENT, 32'h0, 6'h3F);
        send_item(MODE_EVENT, 32'h0, 6'h00);
        send_item(MODE_EVENT, 32'h5, 6'h15);
    endtask

    // interval taken across the timer wrap, edges of the catch-all bin
    task automatic test_timer_wrap();
        write_period(32'd100);
        send_item(MODE_EVENT, 32'hFFFF_FFF0, 6'd0);
        send_item(MODE_EVENT, 32'hFFFF_FFF0 + 32'd100, 6'd0);
        send_item(MODE_EVENT, last_sent_stamp + 32'd99, 6'd0);
        send_item(MODE_EVENT, last_sent_stamp + 32'd163, 6'd0);
        send_item(MODE_EVENT, last_sent_stamp + 32'd162, 6'd0);
        send_item(MODE_EVENT, last_sent_stamp + 32'd37, 6'd0);
    endtask

    // full-scale period and deviation, then read the touched bins
    task automatic test_extreme_period();
        write_period(32'hFFFF_FFFF);
        send_item(MODE_EVENT, last_sent_stamp, 6'h2A);
        send_item(MODE_EVENT, last_sent_stamp + 32'hFFFF_FFFF, 6'h15);
        send_item(MODE_READ, 32'hFFFF_FFFF, 6'd0);
        send_item(MODE_READ, 32'h0, 6'd1);
        send_item(MODE_READ, 32'hAAAA_5555, 6'd62);
        send_item(MODE_READ, 32'h5555_AAAA, 6'd63);
        // count wrap past 2^32 is out of reach within any practical run
    endtask

    // long random traffic over several period settings
    task automatic test_random_traffic();
        logic [31:0] period;
        int          phase;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: period = $urandom_range(1, 200);
                1: period = 32'h0;
                2: period = 32'hFFFF_FFFF;
                3: period = $urandom;
                default: period = $urandom_range(64, 5000);
            endcase
            write_period(period);
            repeat (330) send_random_item(period);
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_back_to_back();
        logic [31:0] period;
        period = $urandom_range(20, 80);
        write_period(period);
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        repeat (200) send_random_item(period);
    endtask

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("period_jitter_histogram_tb: done, errors");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_mode = MODE_EVENT;
        i_timestamp = '0;
        i_bin_index = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        nominal_period = '0;
        prev_stamp = '0;
        baseline_set = 1'b0;
        peak_dev = '0;
        foreach (bin_tally[k]) bin_tally[k] = '0;
        last_sent_stamp = '0;
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        error_count = 0;
        n_intervals = 0;
        n_clamped = 0;
        n_baselines = 0;
        n_reads = 0;
        n_checked = 0;
        n_periods = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_bins();
        test_baseline_zero();
        test_timer_wrap();
        test_extreme_period();
        test_random_traffic();
        test_back_to_back();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("period_jitter_histogram_tb: %0d intervals (%0d in the last bin),",
                 n_intervals, n_clamped);
        $display("    %0d reads, %0d baselines, %0d results compared over %0d periods",
                 n_reads, n_baselines, n_checked, n_periods);
        if (error_count == 0) begin
            $display("period_jitter_histogram_tb: done, clean");
        end else begin
            $display("period_jitter_histogram_tb: done, errors");
        end
        $finish;
    end

endmodule
